// ===== hw/rtl/mmm_pkg.sv =====
// Package for the modular matrix multiply block: sizes, modulus, codes and
// shared types. No dependencies; imported by mmm_mac and the top level.
package mmm_pkg;

  // Element and index sizes
  localparam int unsigned ELEM_W  = 12;
  localparam int unsigned MAX_DIM = 16;
  localparam int unsigned IDX_W   = $clog2(MAX_DIM);
  localparam int unsigned DIM_W   = IDX_W + 1;
  localparam int unsigned ADDR_W  = 2 * IDX_W;
  localparam int unsigned DEPTH   = MAX_DIM * MAX_DIM;

  // Modulus and the accumulator/reduction sizes that follow from it
  localparam int unsigned     MODULUS = 3329;
  localparam int unsigned     PROD_W  = 2 * ELEM_W;
  localparam int unsigned     ACC_W   = PROD_W + IDX_W;
  // Barrett constants: a shift above ACC_W keeps the quotient estimate
  // at most one below the true quotient
  localparam int unsigned     BAR_K   = ACC_W + 4;
  localparam longint unsigned BAR_M   = (64'd1 << BAR_K) / MODULUS;
  localparam int unsigned     BAR_M_W = $clog2(BAR_M + 1);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_OF_A  = 2'd0,
    CFG_INNER_SIZE = 2'd1,
    CFG_COLS_OF_B  = 2'd2
  } cfg_idx_e;

  // Command codes
  localparam int unsigned CMD_W = 2;
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } state_e;

  // Tags that travel with each element pair into the MAC unit
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

// ===== hw/rtl/mmm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mmm_ram #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned WIDTH  = 12,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mmm_mac.sv =====
// Multiply-accumulate unit with a pipelined Barrett reduction mod q.
// Depends on mmm_pkg.
module mmm_mac (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mmm_pkg::mac_ctrl_t          ctrl_i,
  input  logic [mmm_pkg::ELEM_W-1:0]  a_i,
  input  logic [mmm_pkg::ELEM_W-1:0]  b_i,
  output logic                        done_o,
  output logic [mmm_pkg::ELEM_W-1:0]  result_o
);
  import mmm_pkg::*;

  localparam int unsigned        BP_W = ACC_W + BAR_M_W;
  localparam logic [ACC_W-1:0]   QExt = ACC_W'(MODULUS);
  localparam logic [BAR_M_W-1:0] MExt = BAR_M_W'(BAR_M);

  logic [PROD_W-1:0] prod_q;
  mac_ctrl_t         pctrl_q;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [ACC_W-1:0]  sum;
  logic [BP_W-1:0]   bprod_q;
  logic [ACC_W-1:0]  quot;
  logic [ACC_W-1:0]  rem_q, rem_d;
  logic              sum_vld_q;
  logic              est_vld_q;
  logic              done_q;

  // Product stage
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pctrl_q <= '0;
    end else begin
      pctrl_q <= ctrl_i;
    end
  end

  // Running sum; the first term restarts it
  assign sum   = (pctrl_q.first ? '0 : acc_q) + ACC_W'(prod_q);
  assign acc_d = pctrl_q.vld ? sum : acc_q;

  // Barrett: the estimate is floor(x/q) or one less, so x - est*q < 2q.
  // acc_q holds still until the next read, which cannot start before done.
  assign quot  = ACC_W'(bprod_q[BP_W-1:BAR_K]);
  assign rem_d = acc_q - quot * QExt;

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    bprod_q <= BP_W'(acc_q) * BP_W'(MExt);
    rem_q   <= rem_d;
  end

  // Stage tags: sum ready, estimate ready, remainder ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
      est_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      sum_vld_q <= pctrl_q.vld & pctrl_q.last;
      est_vld_q <= sum_vld_q;
      done_q    <= est_vld_q;
    end
  end

  // Final conditional subtract
  assign done_o   = done_q;
  assign result_o = (rem_q >= QExt) ? ELEM_W'(rem_q - QExt) : ELEM_W'(rem_q);

endmodule

// ===== hw/rtl/modular_matrix_multiply.sv =====
// Top level of the modular matrix multiply block: command decode, operand
// stores, read sequencer and result register. Depends on mmm_pkg, mmm_ram, mmm_mac.
//
// A and B live in two 256-entry synchronous RAMs addressed row*16+col. For a
// load busy stays low; an out-of-range load or read, or an in-range read with
// inner_size zero, gives a result strobe in the cycle after start. A read in
// range walks inner_size element pairs through one multiply-accumulate unit,
// one pair per cycle, then reduces the sum mod 3329 with a registered Barrett
// estimate, a registered remainder and one conditional subtract; busy stays
// high until the reduced result is ready and drops as the result strobe rises.
// result_valid_o is high for exactly one cycle per result and cannot be held
// off. Stores hold garbage until written; read only elements that were loaded.
module modular_matrix_multiply (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [mmm_pkg::CMD_W-1:0]      command_i,
  input  logic [mmm_pkg::IDX_W-1:0]      row_index_i,
  input  logic [mmm_pkg::IDX_W-1:0]      col_index_i,
  input  logic [mmm_pkg::ELEM_W-1:0]     elem_value_i,
  input  logic                           cfg_we_i,
  input  logic [mmm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mmm_pkg::DIM_W-1:0]      cfg_wdata_i,
  output logic                           result_valid_o,
  output logic [mmm_pkg::ELEM_W-1:0]     product_value_o,
  output logic                           range_error_o
);
  import mmm_pkg::*;

  localparam logic [DIM_W-1:0] MaxDim = DIM_W'(MAX_DIM);

  logic [DIM_W-1:0] rows_q, inner_q, cols_q;
  logic [DIM_W-1:0] dim_m, dim_n, dim_p;
  logic [DIM_W-1:0] row_ext, col_ext;

  state_e            state_q, state_d;
  logic [DIM_W-1:0]  k_q, k_d;
  logic [IDX_W-1:0]  row_q, row_d, col_q, col_d;
  mac_ctrl_t         ctrl_d, ctrl_q;

  logic              a_we, b_we;
  logic [ADDR_W-1:0] wr_addr, a_raddr, b_raddr;
  logic [ELEM_W-1:0] a_rdata, b_rdata;

  logic              mac_done;
  logic [ELEM_W-1:0] mac_result;

  logic              res_valid_q, res_valid_d;
  logic [ELEM_W-1:0] res_value_q, res_value_d;
  logic              res_err_q, res_err_d;
  logic              accept;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= MaxDim;
      inner_q <= MaxDim;
      cols_q  <= MaxDim;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ROWS_OF_A:  rows_q  <= cfg_wdata_i;
        CFG_INNER_SIZE: inner_q <= cfg_wdata_i;
        CFG_COLS_OF_B:  cols_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Dimensions saturate at the store size
  assign dim_m = (rows_q  > MaxDim) ? MaxDim : rows_q;
  assign dim_n = (inner_q > MaxDim) ? MaxDim : inner_q;
  assign dim_p = (cols_q  > MaxDim) ? MaxDim : cols_q;

  assign row_ext = {1'b0, row_index_i};
  assign col_ext = {1'b0, col_index_i};
  assign accept  = start && (state_q == ST_IDLE);
  assign wr_addr = {row_index_i, col_index_i};

  // Read addresses: row of A and column of B, stepped by k
  assign a_raddr = {row_q, k_q[IDX_W-1:0]};
  assign b_raddr = {k_q[IDX_W-1:0], col_q};

  // Sequencer: decode, issue reads, wait for the MAC result
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    row_d       = row_q;
    col_d       = col_q;
    a_we        = 1'b0;
    b_we        = 1'b0;
    ctrl_d      = '0;
    res_valid_d = 1'b0;
    res_value_d = '0;
    res_err_d   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(command_i))
            CMD_LOAD_A: begin
              if (row_ext < dim_m && col_ext < dim_n) begin
                a_we = 1'b1;
              end else begin
                res_valid_d = 1'b1;
                res_err_d   = 1'b1;
              end
            end
            CMD_LOAD_B: begin
              if (row_ext < dim_n && col_ext < dim_p) begin
                b_we = 1'b1;
              end else begin
                res_valid_d = 1'b1;
                res_err_d   = 1'b1;
              end
            end
            CMD_READ: begin
              if (row_ext >= dim_m || col_ext >= dim_p) begin
                res_valid_d = 1'b1;
                res_err_d   = 1'b1;
              end else if (dim_n == '0) begin
                // empty dot product
                res_valid_d = 1'b1;
              end else begin
                row_d   = row_index_i;
                col_d   = col_index_i;
                k_d     = '0;
                state_d = ST_ISSUE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        ctrl_d.vld   = 1'b1;
        ctrl_d.first = (k_q == '0);
        ctrl_d.last  = ((k_q + DIM_W'(1)) == dim_n);
        k_d          = k_q + DIM_W'(1);
        if (ctrl_d.last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mac_done) begin
          res_valid_d = 1'b1;
          res_value_d = mac_result;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ctrl_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctrl_q      <= ctrl_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q         <= k_d;
    row_q       <= row_d;
    col_q       <= col_d;
    res_value_q <= res_value_d;
    res_err_q   <= res_err_d;
  end

  // Operand stores
  mmm_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ELEM_W),
    .ADDR_W(ADDR_W)
  ) u_a_ram (
    .clk_i  (clk_i),
    .we_i   (a_we),
    .waddr_i(wr_addr),
    .wdata_i(elem_value_i),
    .raddr_i(a_raddr),
    .rdata_o(a_rdata)
  );

  mmm_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ELEM_W),
    .ADDR_W(ADDR_W)
  ) u_b_ram (
    .clk_i  (clk_i),
    .we_i   (b_we),
    .waddr_i(wr_addr),
    .wdata_i(elem_value_i),
    .raddr_i(b_raddr),
    .rdata_o(b_rdata)
  );

  // Multiply-accumulate and reduction; ctrl_q lines up with read data
  mmm_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl_q),
    .a_i     (a_rdata),
    .b_i     (b_rdata),
    .done_o  (mac_done),
    .result_o(mac_result)
  );

  assign busy            = (state_q != ST_IDLE);
  assign result_valid_o  = res_valid_q;
  assign product_value_o = res_value_q;
  assign range_error_o   = res_err_q;

endmodule
